[sv/bfap_pkg.sv]
// ---------------------------------------------------------------------------
// bfap_pkg
// types, constants and helpers shared by the beacon parser modules
// ---------------------------------------------------------------------------
package bfap_pkg;

  localparam int unsigned MaxFrameBytes = 2048;
  localparam logic [11:0] MAX_FRAME = 12'(MaxFrameBytes);

  localparam logic [7:0] FC_BEACON = 8'h80;
  localparam logic [7:0] FC_PROBE  = 8'h50;
  localparam logic [7:0] ID_SSID   = 8'd0;
  localparam logic [7:0] ID_DS     = 8'd3;
  localparam logic [7:0] ID_RSN    = 8'd48;
  localparam logic [7:0] ID_HT     = 8'd61;
  localparam logic [7:0] ID_VENDOR = 8'd221;

  localparam logic [2:0] SEC_OPEN = 3'd0;
  localparam logic [2:0] SEC_WEP  = 3'd1;
  localparam logic [2:0] SEC_WPA  = 3'd2;
  localparam logic [2:0] SEC_WPA2 = 3'd3;
  localparam logic [2:0] SEC_SAE  = 3'd4;
  localparam logic [2:0] SEC_OWE  = 3'd5;

  localparam logic [2:0] STG_START = 3'd0;
  localparam logic [2:0] STG_SKIP  = 3'd1;
  localparam logic [2:0] STG_CNT2L = 3'd2;
  localparam logic [2:0] STG_CNT2H = 3'd3;
  localparam logic [2:0] STG_AKM   = 3'd4;
  localparam logic [2:0] STG_DONE  = 3'd5;
  localparam logic [2:0] STG_IDLE  = 3'd6;

  typedef struct packed {
    logic       accepted;
    logic [5:0] ssid_len;
  } bfap_status_t;

  typedef struct packed {
    logic       emit_hdr;
    logic       emit_char;
    logic [4:0] rd_addr;
  } bfap_cmd_t;

  function automatic logic chan_ok(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'd149;
    return (c >= 8'd1 && c <= 8'd14) ||
           (c >= 8'd36 && c <= 8'd64 && c[1:0] == 2'b00) ||
           (c >= 8'd100 && c <= 8'd144 && c[1:0] == 2'b00) ||
           (c >= 8'd149 && c <= 8'd165 && d[1:0] == 2'b00);
  endfunction

endpackage

[sv/bfap_datapath.sv]
// ---------------------------------------------------------------------------
// bfap_datapath
// per-byte frame parse, ssid store and output record register
// ---------------------------------------------------------------------------
module bfap_datapath import bfap_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_en,
  input  logic [7:0]   frame_byte,
  input  logic         frame_last,
  input  logic [7:0]   rx_channel,
  input  logic [7:0]   rx_rssi,
  input  bfap_cmd_t    cmd,
  output bfap_status_t status,
  output logic         rec_kind,
  output logic         rec_acc,
  output logic [47:0]  rec_bssid,
  output logic [7:0]   rec_chan,
  output logic [7:0]   rec_rssi,
  output logic [2:0]   rec_sec,
  output logic [5:0]   rec_len,
  output logic [7:0]   rec_char,
  output logic         rec_last
);

  logic [11:0] frame_pos;
  logic        frame_bad;
  logic [47:0] bssid_reg;
  logic [2:0]  security_reg;
  logic [7:0]  channel_reg;
  logic [7:0]  rssi_reg;
  logic [5:0]  ssid_len_reg;
  logic [2:0]  seen_flags;
  logic [7:0]  ie_id_reg;
  logic [7:0]  ie_len_reg;
  logic [7:0]  ie_offset;
  logic [1:0]  ie_phase;
  logic [15:0] rsn_count;
  logic [2:0]  rsn_stage;
  logic [2:0]  rsn_auth_reg;
  logic [7:0]  ssid_mem [32];
  logic [7:0]  rd_data;
  logic        ok_reg;

  logic [11:0] pos_next;
  logic        bad_next;
  logic [47:0] bssid_next;
  logic [2:0]  sec_next, stage_next, auth_next, seen_next;
  logic [7:0]  chan_next, rssi_next, id_next, len_next, off_next;
  logic [5:0]  slen_next;
  logic [1:0]  phase_next;
  logic [15:0] count_next;
  logic        ok_next, wr_en;
  logic [4:0]  wr_addr;
  logic [7:0]  wr_data;

  always_comb begin
    logic [7:0] b;
    logic [15:0] c1, c2;
    logic [8:0] rem;
    logic [7:0] left;
    logic [1:0] at;
    logic miss, done;
    b = frame_byte;
    pos_next = frame_pos; bad_next = frame_bad; bssid_next = bssid_reg;
    sec_next = security_reg; chan_next = channel_reg; rssi_next = rssi_reg;
    slen_next = ssid_len_reg; seen_next = seen_flags; id_next = ie_id_reg;
    len_next = ie_len_reg; off_next = ie_offset; phase_next = ie_phase;
    count_next = rsn_count; stage_next = rsn_stage; auth_next = rsn_auth_reg;
    wr_en = 1'b0; wr_addr = ie_offset[4:0];
    wr_data = (b < 8'h20 || b == 8'h7f) ? 8'h3f : b;
    done = 1'b0;
    c1 = '0; c2 = '0; rem = '0; left = '0; at = '0; miss = 1'b0;
    if (frame_pos == 12'd0) begin
      bad_next = (b != FC_BEACON && b != FC_PROBE);
      bssid_next = '0; sec_next = SEC_OPEN; chan_next = rx_channel; rssi_next = rx_rssi;
      slen_next = '0; seen_next = '0; phase_next = 2'd0;
    end
    if (frame_pos >= MAX_FRAME) begin
      bad_next = 1'b1;
    end else if (frame_pos >= 12'd16 && frame_pos < 12'd22) begin
      if (frame_pos == 12'd16 && b[0]) bad_next = 1'b1;
      case (frame_pos[2:0])
        3'd0:    bssid_next[7:0]   = b;
        3'd1:    bssid_next[15:8]  = b;
        3'd2:    bssid_next[23:16] = b;
        3'd3:    bssid_next[31:24] = b;
        3'd4:    bssid_next[39:32] = b;
        default: bssid_next[47:40] = b;
      endcase
    end else if (frame_pos == 12'd34) begin
      sec_next = b[4] ? SEC_WEP : SEC_OPEN;
    end else if (frame_pos >= 12'd36) begin
      if (phase_next == 2'd0) begin
        id_next = b; phase_next = 2'd1;
      end else if (phase_next == 2'd1) begin
        len_next = b; off_next = '0; stage_next = STG_IDLE;
        case (ie_id_reg)
          ID_SSID: begin
            if (!seen_next[0]) begin
              if (b > 8'd32) bad_next = 1'b1;
              else begin
                seen_next[0] = 1'b1; slen_next = b[5:0]; stage_next = STG_START;
              end
            end
          end
          ID_DS:     if (b == 8'd1) stage_next = STG_START;
          ID_HT:     if (b >= 8'd1 && !seen_next[2]) stage_next = STG_START;
          ID_RSN: begin
            seen_next[1] = 1'b1; auth_next = SEC_WPA2; count_next = '0;
            stage_next = (b < 8'd8) ? STG_IDLE : STG_START;
          end
          ID_VENDOR: if (b >= 8'd4 && !seen_next[1]) stage_next = STG_START;
          default: ;
        endcase
        if (b == 8'd0) done = 1'b1; else phase_next = 2'd2;
      end else begin
        if (ie_id_reg == ID_RSN) begin
          case (rsn_stage)
            STG_START: begin
              if (ie_offset == 8'd0 || ie_offset == 8'd6) count_next = {8'd0, b};
              else if (ie_offset == 8'd1) begin
                if ({b, rsn_count[7:0]} != 16'd1) stage_next = STG_IDLE;
              end else if (ie_offset == 8'd7) begin
                c1 = {b, rsn_count[7:0]};
                if (c1 > 16'((ie_len_reg - 8'd8) >> 2) ||
                    (18'(ie_len_reg) - (18'd8 + {c1, 2'b00})) < 18'd2)
                  stage_next = STG_IDLE;
                else if (c1 == 16'd0) stage_next = STG_CNT2L;
                else begin
                  count_next = {c1[13:0], 2'b00}; stage_next = STG_SKIP;
                end
              end
            end
            STG_SKIP: begin
              count_next = rsn_count - 16'd1;
              if (count_next == 16'd0) stage_next = STG_CNT2L;
            end
            STG_CNT2L: begin
              count_next = {8'd0, b}; stage_next = STG_CNT2H;
            end
            STG_CNT2H: begin
              c2 = {b, rsn_count[7:0]};
              rem = 9'(ie_len_reg) - (9'(ie_offset) + 9'd1);
              if (c2 > 16'(rem[8:2])) stage_next = STG_IDLE;
              else if (c2 == 16'd0) stage_next = STG_DONE;
              else begin
                count_next = c2; stage_next = STG_AKM;
              end
            end
            STG_AKM: begin
              left = rsn_count[7:0]; at = rsn_count[9:8]; miss = rsn_count[10];
              case (at)
                2'd0: miss = (b != 8'h00);
                2'd1: miss = miss | (b != 8'h0f);
                2'd2: miss = miss | (b != 8'hac);
                default: begin
                  if (!miss) begin
                    if (b == 8'd8 || b == 8'd9) auth_next = SEC_SAE;
                    if (b == 8'd18) auth_next = SEC_OWE;
                  end
                  left = left - 8'd1;
                  if (left == 8'd0) stage_next = STG_DONE;
                end
              endcase
              count_next = {5'd0, miss, at + 2'd1, left};
            end
            default: ;
          endcase
        end else if (rsn_stage == STG_START) begin
          case (ie_id_reg)
            ID_SSID: wr_en = 1'b1;
            ID_DS: if (chan_ok(b)) begin
              chan_next = b; seen_next[2] = 1'b1;
            end
            ID_HT: begin
              if (ie_offset == 8'd0 && chan_ok(b)) chan_next = b;
              stage_next = STG_IDLE;
            end
            ID_VENDOR: begin
              if (b != (ie_offset[1:0] == 2'd0 ? 8'h00 : ie_offset[1:0] == 2'd1 ?
                        8'h50 : ie_offset[1:0] == 2'd2 ? 8'hf2 : 8'h01))
                stage_next = STG_IDLE;
              else if (ie_offset == 8'd3) begin
                sec_next = SEC_WPA; stage_next = STG_IDLE;
              end
            end
            default: ;
          endcase
        end
        if (9'(ie_offset) + 9'd1 >= 9'(ie_len_reg)) done = 1'b1;
        else off_next = ie_offset + 8'd1;
      end
      if (done) begin
        if (ie_id_reg == ID_RSN)
          sec_next = (stage_next == STG_IDLE) ? SEC_WPA2 : auth_next;
        phase_next = 2'd0;
      end
    end
    ok_next = !bad_next && (frame_pos >= 12'd35) && phase_next == 2'd0 &&
              bssid_next != '0 && seen_next[0] && chan_ok(chan_next);
    if (frame_last) begin
      pos_next = '0; phase_next = 2'd0;
    end else if (frame_pos != 12'd4095) pos_next = frame_pos + 12'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0; frame_bad <= 1'b0; bssid_reg <= '0; security_reg <= SEC_OPEN;
      channel_reg <= '0; rssi_reg <= '0; ssid_len_reg <= '0; seen_flags <= '0;
      ie_id_reg <= '0; ie_len_reg <= '0; ie_offset <= '0; ie_phase <= '0;
      rsn_count <= '0; rsn_stage <= STG_START; rsn_auth_reg <= SEC_WPA2; ok_reg <= 1'b0;
    end else if (byte_en) begin
      frame_pos <= pos_next; frame_bad <= bad_next; bssid_reg <= bssid_next;
      security_reg <= sec_next; channel_reg <= chan_next; rssi_reg <= rssi_next;
      ssid_len_reg <= slen_next; seen_flags <= seen_next; ie_id_reg <= id_next;
      ie_len_reg <= len_next; ie_offset <= off_next; ie_phase <= phase_next;
      rsn_count <= count_next; rsn_stage <= stage_next; rsn_auth_reg <= auth_next;
      ok_reg <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en && wr_en) ssid_mem[wr_addr] <= wr_data;
    rd_data <= ssid_mem[cmd.rd_addr];
  end

  assign status.accepted = ok_reg;
  assign status.ssid_len = ssid_len_reg;

  // output record register
  always_ff @(posedge clk) begin
    if (cmd.emit_hdr) begin
      rec_kind <= 1'b0; rec_acc <= ok_reg; rec_char <= '0;
      rec_bssid <= ok_reg ? bssid_reg : '0;
      rec_chan <= ok_reg ? channel_reg : '0;
      rec_rssi <= ok_reg ? rssi_reg : '0;
      rec_sec <= ok_reg ? security_reg : SEC_OPEN;
      rec_len <= ok_reg ? ssid_len_reg : '0;
      rec_last <= !ok_reg || ssid_len_reg == 6'd0;
    end else if (cmd.emit_char) begin
      rec_kind <= 1'b1; rec_char <= rd_data;
      rec_last <= (cmd.rd_addr == 5'(ssid_len_reg - 6'd1));
    end
  end

endmodule

[sv/bfap_ctrl.sv]
// ---------------------------------------------------------------------------
// bfap_ctrl
// sequencer: byte intake, then summary and ssid drain
// ---------------------------------------------------------------------------
module bfap_ctrl import bfap_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_fire,
  input  logic         in_last,
  input  logic         out_ready,
  input  bfap_status_t status,
  output bfap_cmd_t    cmd,
  output logic         in_ready,
  output logic         out_valid
);

  typedef enum logic [3:0] {
    S_RUN  = 4'b0001,
    S_HDR  = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [5:0] idx, idx_next;
  logic       ov, ov_next;

  assign in_ready = (state == S_RUN);
  assign out_valid = ov;

  always_comb begin
    state_next = state; idx_next = idx; ov_next = ov;
    cmd.emit_hdr = 1'b0; cmd.emit_char = 1'b0; cmd.rd_addr = idx[4:0];
    case (state)
      S_RUN: if (in_fire && in_last) state_next = S_HDR;
      S_HDR: begin
        cmd.emit_hdr = 1'b1; ov_next = 1'b1; idx_next = '0; state_next = S_OUT;
      end
      // ram read address was presented last cycle; data valid now
      S_RD: begin
        cmd.emit_char = 1'b1; ov_next = 1'b1; state_next = S_OUT;
      end
      S_OUT: if (out_ready) begin
        ov_next = 1'b0;
        if (!status.accepted || idx == status.ssid_len) state_next = S_RUN;
        else begin
          idx_next = idx + 6'd1;
          state_next = S_RD;
        end
      end
      default: state_next = S_RUN;
    endcase
    if (state == S_RD) cmd.rd_addr = 5'(idx - 6'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN; idx <= '0; ov <= 1'b0;
    end else begin
      state <= state_next; idx <= idx_next; ov <= ov_next;
    end
  end

endmodule

[sv/beacon_frame_ap_parser_unit.sv]
// ---------------------------------------------------------------------------
// beacon_frame_ap_parser_unit
// 802.11 beacon / probe-response parser producing an access point record
// ---------------------------------------------------------------------------
// Frame bytes are taken one per cycle. After the last byte the block takes no
// input until the run is drained: the summary record is built in the header
// state and then presented, and for an accepted frame each ssid character
// follows through the ssid ram read and then the output register.
module beacon_frame_ap_parser_unit import bfap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // frame_byte, rx_channel, rx_rssi
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,  // accepted, bssid_out, channel_out, rssi_out,
                                // security_out, ssid_len_out, ssid_char, pad
  output logic        m_tuser,  // record_kind
  output logic        m_tlast
);

  bfap_status_t status;
  bfap_cmd_t    cmd;
  logic         in_fire;
  logic         rec_kind, rec_acc, rec_last;
  logic [47:0]  rec_bssid;
  logic [7:0]   rec_chan, rec_rssi, rec_char;
  logic [2:0]   rec_sec;
  logic [5:0]   rec_len;

  assign in_fire = s_tvalid && s_tready;

  bfap_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_tlast), .out_ready(m_tready), .status, .cmd,
    .in_ready(s_tready), .out_valid(m_tvalid)
  );

  bfap_datapath u_dp (
    .clk, .rst, .byte_en(in_fire), .frame_byte(s_tdata[7:0]), .frame_last(s_tlast),
    .rx_channel(s_tdata[15:8]), .rx_rssi(s_tdata[23:16]), .cmd, .status,
    .rec_kind, .rec_acc, .rec_bssid, .rec_chan, .rec_rssi, .rec_sec, .rec_len,
    .rec_char, .rec_last
  );

  assign m_tdata = {6'd0, rec_char, rec_len, rec_sec, rec_rssi, rec_chan,
                    rec_bssid, rec_acc};
  assign m_tuser = rec_kind;
  assign m_tlast = rec_last;

  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken during drain");
  a_hdr_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tlast) |=> ##1 (m_tvalid && !m_tuser))
    else $error("summary record missing");
  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> m_tlast) else $error("rejected run not closed");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for beacon_frame_ap_parser_unit
// Sends 802.11 management frames one byte per transaction. The first part is
// a table of hand-built frames: rejections, every security class, and the
// channel overrides. Random frames follow, most of them well formed. Each
// access point record from the block is checked against a byte-level parser
// model that is kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bfap_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_FRAMES = 135;

  typedef struct packed {
    logic        kind;
    logic        acc;
    logic [47:0] bssid;
    logic [7:0]  chan;
    logic [7:0]  rssi;
    logic [2:0]  sec;
    logic [5:0]  slen;
    logic [7:0]  schar;
    logic        last;
  } ap_record_t;

  typedef enum int {
    F_OPEN_EMPTY_SSID, F_SSID32_CTRL, F_PROBE_WEP, F_SHORT, F_ONE_BYTE, F_BAD_FC,
    F_GROUP_BSSID, F_ZERO_BSSID, F_SSID33, F_TRUNCATED, F_NO_SSID, F_BAD_CHAN,
    F_DS_CHAN, F_HT_CHAN, F_HT_AFTER_DS, F_WPA2, F_SAE, F_OWE, F_RSN_SHORT,
    F_RSN_BAD_VER, F_RSN_OVERRUN, F_WPA, F_WPA_AFTER_RSN, F_OVERSIZE,
    F_SECOND_SSID
  } frame_case_t;

  typedef struct {
    frame_case_t fcase;
    bit          known;  // accepted bit can be read off directly
    bit          acc;
  } frame_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [87:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  beacon_frame_ap_parser_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  ap_record_t ap_q[$];
  logic [7:0] frame_q[$];
  logic [7:0] body_q[$];
  int errors = 0;
  int cycles = 0;
  int frames_sent = 0;
  int frames_accepted = 0;
  int records_seen = 0;
  bit tx_calm = 0;
  bit rx_calm = 0;
  bit last_acc;

  // parser model state
  logic [11:0] p_pos;
  bit          p_bad;
  logic [47:0] p_bssid;
  logic [2:0]  p_sec;
  logic [7:0]  p_chan;
  logic [7:0]  p_rssi;
  logic [7:0]  p_ssid[32];
  logic [5:0]  p_slen;
  logic [2:0]  p_seen;
  logic [7:0]  p_id;
  logic [7:0]  p_len;
  logic [7:0]  p_off;
  logic [1:0]  p_phase;
  logic [15:0] p_cnt;
  logic [2:0]  p_stg;
  logic [2:0]  p_auth;

  function automatic bit channel_valid(int c);
    if (c >= 1 && c <= 14) return 1;
    if (c >= 36 && c <= 64) return (c % 4) == 0;
    if (c >= 100 && c <= 144) return (c % 4) == 0;
    if (c >= 149 && c <= 165) return ((c - 149) % 4) == 0;
    return 0;
  endfunction

  task automatic elem_open();
    int n;
    n = p_len;
    p_stg = STG_IDLE;
    case (p_id)
      ID_SSID: begin
        if (!p_seen[0]) begin
          if (n > 32) p_bad = 1;
          else begin
            p_seen[0] = 1'b1;
            p_slen = 6'(n);
            p_stg = STG_START;
          end
        end
      end
      ID_DS: if (n == 1) p_stg = STG_START;
      ID_HT: if (n >= 1 && !p_seen[2]) p_stg = STG_START;
      ID_RSN: begin
        p_seen[1] = 1'b1;
        p_auth = SEC_WPA2;
        p_cnt = '0;
        p_stg = (n < 8) ? STG_IDLE : STG_START;
      end
      ID_VENDOR: if (n >= 4 && !p_seen[1]) p_stg = STG_START;
      default: ;
    endcase
  endtask

  task automatic rsn_walk(int o, logic [7:0] b);
    int n, c, left, at;
    bit miss;
    n = p_len;
    case (p_stg)
      STG_START: begin
        if (o == 0 || o == 6) p_cnt = {8'h00, b};
        else if (o == 1) begin
          if ((int'(p_cnt) | (int'(b) << 8)) != 1) p_stg = STG_IDLE;
        end else if (o == 7) begin
          c = int'(p_cnt) | (int'(b) << 8);
          if (c > (n - 8) / 4 || n - (8 + 4 * c) < 2) p_stg = STG_IDLE;
          else if (c == 0) p_stg = STG_CNT2L;
          else begin
            p_cnt = 16'(4 * c);
            p_stg = STG_SKIP;
          end
        end
      end
      STG_SKIP: begin
        p_cnt = p_cnt - 16'd1;
        if (p_cnt == 0) p_stg = STG_CNT2L;
      end
      STG_CNT2L: begin
        p_cnt = {8'h00, b};
        p_stg = STG_CNT2H;
      end
      STG_CNT2H: begin
        c = int'(p_cnt) | (int'(b) << 8);
        if (c > (n - (o + 1)) / 4) p_stg = STG_IDLE;
        else if (c == 0) p_stg = STG_DONE;
        else begin
          p_cnt = 16'(c);
          p_stg = STG_AKM;
        end
      end
      STG_AKM: begin
        left = p_cnt[7:0];
        at = p_cnt[9:8];
        miss = p_cnt[10];
        if (at == 0) miss = (b != 8'h00);
        else if (at == 1) miss |= (b != 8'h0f);
        else if (at == 2) miss |= (b != 8'hac);
        else begin
          if (!miss) begin
            if (b == 8'd8 || b == 8'd9) p_auth = SEC_SAE;
            if (b == 8'd18) p_auth = SEC_OWE;
          end
          left = (left - 1) & 255;
          if (left == 0) p_stg = STG_DONE;
        end
        p_cnt = {5'b0, miss, 2'(at + 1), 8'(left)};
      end
      default: ;
    endcase
  endtask

  task automatic elem_byte(int o, logic [7:0] b);
    logic [7:0] oui[4];
    oui = '{8'h00, 8'h50, 8'hf2, 8'h01};
    if (p_id == ID_RSN) rsn_walk(o, b);
    else if (p_stg == STG_START) begin
      case (p_id)
        ID_SSID: p_ssid[o % 32] = (b < 8'h20 || b == 8'h7f) ? 8'h3f : b;
        ID_DS: if (channel_valid(b)) begin
          p_chan = b;
          p_seen[2] = 1'b1;
        end
        ID_HT: begin
          if (o == 0 && channel_valid(b)) p_chan = b;
          p_stg = STG_IDLE;
        end
        ID_VENDOR: begin
          if (b != oui[o % 4]) p_stg = STG_IDLE;
          else if (o == 3) begin
            p_sec = SEC_WPA;
            p_stg = STG_IDLE;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic elem_close();
    if (p_id == ID_RSN) p_sec = (p_stg == STG_IDLE) ? SEC_WPA2 : p_auth;
    p_phase = 2'd0;
  endtask

  // advance the model by one accepted byte, queueing any records it causes
  task automatic parse_byte(logic [7:0] b, bit fin, logic [7:0] ch, logic [7:0] rs);
    int pos, n;
    bit ok;
    ap_record_t r;
    pos = p_pos;
    if (pos == 0) begin
      p_bad = 0; p_bssid = '0; p_sec = SEC_OPEN; p_chan = ch; p_rssi = rs;
      p_slen = '0; p_seen = '0; p_phase = 2'd0;
      if (b != FC_BEACON && b != FC_PROBE) p_bad = 1;
    end
    if (pos >= MaxFrameBytes) p_bad = 1;
    else if (pos >= 16 && pos < 22) begin
      if (pos == 16 && b[0]) p_bad = 1;
      p_bssid[8*(pos-16) +: 8] = b;
    end else if (pos == 34) p_sec = b[4] ? SEC_WEP : SEC_OPEN;
    else if (pos >= 36) begin
      if (p_phase == 2'd0) begin
        p_id = b;
        p_phase = 2'd1;
      end else if (p_phase == 2'd1) begin
        p_len = b;
        p_off = '0;
        elem_open();
        if (b == 0) elem_close();
        else p_phase = 2'd2;
      end else begin
        elem_byte(p_off, b);
        if (int'(p_off) + 1 >= int'(p_len)) elem_close();
        else p_off = p_off + 8'd1;
      end
    end
    if (!fin) begin
      p_pos = (pos < 4095) ? 12'(pos + 1) : 12'd4095;
      return;
    end
    p_pos = '0;
    ok = !p_bad && pos + 1 >= 36 && p_phase == 2'd0 && p_bssid != 0 && p_seen[0] &&
         channel_valid(p_chan);
    p_phase = 2'd0;
    last_acc = ok;
    if (!ok) begin
      r = '0;
      r.last = 1'b1;
      ap_q.push_back(r);
      return;
    end
    frames_accepted++;
    n = p_slen;
    for (int k = 0; k <= n; k++) begin
      r.kind = (k != 0);
      r.acc = 1'b1;
      r.bssid = p_bssid;
      r.chan = p_chan;
      r.rssi = p_rssi;
      r.sec = p_sec;
      r.slen = 6'(n);
      r.schar = (k == 0) ? 8'h00 : p_ssid[k-1];
      r.last = (k == n);
      ap_q.push_back(r);
    end
  endtask

  // ---- frame construction ----
  function automatic void add_header(logic [7:0] fc, logic [47:0] bssid, logic [7:0] cap);
    frame_q.delete();
    for (int i = 0; i < 36; i++) frame_q.push_back(8'($urandom));
    frame_q[0] = fc;
    for (int i = 0; i < 6; i++) frame_q[16+i] = bssid[8*i +: 8];
    frame_q[34] = cap;
  endfunction

  function automatic void add_elem(logic [7:0] id);
    frame_q.push_back(id);
    frame_q.push_back(8'(body_q.size()));
    foreach (body_q[i]) frame_q.push_back(body_q[i]);
    body_q.delete();
  endfunction

  function automatic void add_ssid(int len, bit printable);
    repeat (len) body_q.push_back(printable ? 8'($urandom_range(32, 126)) : 8'($urandom));
    add_elem(ID_SSID);
  endfunction

  function automatic void add_byte_elem(logic [7:0] id, logic [7:0] v);
    body_q.push_back(v);
    add_elem(id);
  endfunction

  // akm < 0 picks a random suite type per entry; claimed counts may differ from
  // what is written, which makes the element overrun
  function automatic void add_rsn(int ver, int c1, int nakm, int akm, bit cap);
    int t;
    body_q.push_back(8'(ver)); body_q.push_back(8'(ver >> 8));
    body_q.push_back(8'h00); body_q.push_back(8'h0f);
    body_q.push_back(8'hac); body_q.push_back(8'h04);
    body_q.push_back(8'(c1)); body_q.push_back(8'(c1 >> 8));
    repeat ((c1 > 3) ? 1 : c1) begin
      body_q.push_back(8'h00); body_q.push_back(8'h0f);
      body_q.push_back(8'hac); body_q.push_back(8'h04);
    end
    body_q.push_back(8'(nakm)); body_q.push_back(8'(nakm >> 8));
    repeat ((nakm > 4) ? 1 : nakm) begin
      case ($urandom_range(9))
        0: t = 8'($urandom);
        1: t = 0;
        default: t = 15;
      endcase
      body_q.push_back(8'(t == 0 ? $urandom : 0));
      body_q.push_back(t == 0 ? 8'($urandom) : 8'h0f);
      body_q.push_back(t == 0 ? 8'($urandom) : 8'hac);
      if (akm >= 0) t = akm;
      else case ($urandom_range(5))
        0: t = 8; 1: t = 9; 2: t = 18; 3: t = 2;
        default: t = $urandom_range(255);
      endcase
      body_q.push_back(8'(t));
    end
    if (cap) begin
      body_q.push_back(8'($urandom)); body_q.push_back(8'($urandom));
    end
    add_elem(ID_RSN);
  endfunction

  function automatic void add_wpa(bit good);
    body_q.push_back(8'h00); body_q.push_back(8'h50);
    body_q.push_back(8'hf2); body_q.push_back(good ? 8'h01 : 8'($urandom_range(2, 255)));
    body_q.push_back(8'h01); body_q.push_back(8'h00);
    add_elem(ID_VENDOR);
  endfunction

  function automatic logic [47:0] unicast_bssid();
    logic [47:0] a;
    a = {$urandom, $urandom};
    a[0] = 1'b0;
    a[8] = 1'b1;
    return a;
  endfunction

  function automatic logic [7:0] good_channel();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 165)); while (!channel_valid(c));
    return c;
  endfunction

  // ---- stimulus ----
  task automatic send_frame(logic [7:0] ch, logic [7:0] rs);
    for (int i = 0; i < frame_q.size(); i++) begin
      while (!tx_calm && $urandom_range(99) < 34) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {rs, ch, frame_q[i]};
      s_tlast <= (i == frame_q.size() - 1);
      do @(posedge clk); while (!s_tready);
      parse_byte(frame_q[i], i == frame_q.size() - 1, ch, rs);
      @(negedge clk);
    end
    frames_sent++;
  endtask

  task automatic build_case(frame_case_t fc, output logic [7:0] ch, output logic [7:0] rs);
    ch = 8'd6;
    rs = 8'($urandom);
    add_header(FC_BEACON, unicast_bssid(), 8'h01);
    case (fc)
      F_OPEN_EMPTY_SSID: begin
        add_ssid(0, 1);
        rs = 8'h80;
      end
      F_SSID32_CTRL: begin
        for (int i = 0; i < 32; i++)
          body_q.push_back((i % 3 == 0) ? 8'($urandom_range(0, 31)) :
                           (i % 3 == 1) ? 8'h7f : 8'hff);
        add_elem(ID_SSID);
        rs = 8'h7f;
      end
      F_PROBE_WEP: begin
        frame_q[0] = FC_PROBE;
        frame_q[34] = 8'hff;
        add_ssid(5, 1);
        ch = 8'd165;
      end
      F_SHORT: begin
        frame_q = frame_q[0:34];
      end
      F_ONE_BYTE: frame_q = frame_q[0:0];
      F_BAD_FC: begin
        frame_q[0] = 8'h81;
        add_ssid(3, 1);
      end
      F_GROUP_BSSID: begin
        frame_q[16] = 8'hff;
        add_ssid(3, 1);
      end
      F_ZERO_BSSID: begin
        for (int i = 16; i < 22; i++) frame_q[i] = 8'h00;
        add_ssid(3, 1);
      end
      F_SSID33: add_ssid(33, 1);
      F_TRUNCATED: begin
        add_ssid(4, 1);
        body_q.push_back(8'h11); body_q.push_back(8'h22); body_q.push_back(8'h33);
        add_elem(8'd7);
        frame_q = frame_q[0:frame_q.size()-2];
      end
      F_NO_SSID: add_byte_elem(ID_DS, 8'd11);
      F_BAD_CHAN: begin
        add_ssid(2, 1);
        ch = 8'd255;
      end
      F_DS_CHAN: begin
        add_ssid(3, 1);
        add_byte_elem(ID_DS, 8'd149);
        ch = 8'd0;
      end
      F_HT_CHAN: begin
        add_ssid(3, 1);
        body_q.push_back(8'd44); body_q.push_back(8'h05); body_q.push_back(8'h00);
        add_elem(ID_HT);
      end
      F_HT_AFTER_DS: begin
        add_byte_elem(ID_DS, 8'd1);
        add_ssid(2, 1);
        add_byte_elem(ID_HT, 8'd36);
      end
      F_WPA2: begin
        add_ssid(4, 1);
        add_rsn(1, 1, 1, 2, 1);
      end
      F_SAE: begin
        add_ssid(4, 1);
        add_rsn(1, 2, 2, 8, 1);
      end
      F_OWE: begin
        add_ssid(4, 1);
        add_rsn(1, 0, 1, 18, 0);
      end
      F_RSN_SHORT: begin
        add_ssid(1, 1);
        body_q = '{8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h04, 8'h00};
        add_elem(ID_RSN);
      end
      F_RSN_BAD_VER: begin
        add_ssid(1, 1);
        add_rsn(2, 1, 1, 8, 1);
      end
      F_RSN_OVERRUN: begin
        add_ssid(1, 1);
        add_rsn(1, 1, 300, 9, 0);
      end
      F_WPA: begin
        add_ssid(2, 1);
        add_wpa(1);
      end
      F_WPA_AFTER_RSN: begin
        add_ssid(2, 1);
        add_rsn(1, 1, 1, 9, 1);
        add_wpa(1);
      end
      F_OVERSIZE: begin
        add_ssid(2, 1);
        while (frame_q.size() < MaxFrameBytes + 40) begin
          repeat (200) body_q.push_back(8'($urandom));
          add_elem(8'd50);
        end
      end
      F_SECOND_SSID: begin
        add_ssid(3, 0);
        add_ssid(40, 1);
      end
      default: ;
    endcase
  endtask

  function automatic void build_random(output logic [7:0] ch, output logic [7:0] rs);
    int nel;
    rs = 8'($urandom);
    ch = ($urandom_range(9) < 8) ? good_channel() : 8'($urandom);
    if ($urandom_range(99) < 12) begin
      frame_q.delete();
      repeat ($urandom_range(1, 70)) frame_q.push_back(8'($urandom));
      return;
    end
    add_header(($urandom_range(19) == 0) ? 8'($urandom) :
               ($urandom_range(1) ? FC_BEACON : FC_PROBE),
               ($urandom_range(19) == 0) ? {$urandom, $urandom} : unicast_bssid(),
               8'($urandom));
    nel = $urandom_range(1, 5);
    for (int e = 0; e < nel; e++) begin
      case ($urandom_range(9))
        0, 1, 2: add_ssid(($urandom_range(15) == 0) ? $urandom_range(0, 34) :
                          $urandom_range(0, 10), $urandom_range(1));
        3: add_byte_elem(ID_DS, ($urandom_range(1)) ? good_channel() : 8'($urandom));
        4: add_byte_elem(ID_HT, ($urandom_range(1)) ? good_channel() : 8'($urandom));
        5, 6: add_rsn(($urandom_range(9) == 0) ? $urandom_range(0, 3) : 1,
                      $urandom_range(0, 2), $urandom_range(0, 3), -1,
                      $urandom_range(1));
        7: add_wpa($urandom_range(3) != 0);
        default: begin
          repeat ($urandom_range(0, 6)) body_q.push_back(8'($urandom));
          add_elem(8'($urandom));
        end
      endcase
    end
    if ($urandom_range(19) == 0)
      frame_q = frame_q[0:frame_q.size() - 1 - $urandom_range(1, 3)];
  endfunction

  // ---- result checking ----
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    ap_record_t want;
    ap_record_t got;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      records_seen++;
      got = {m_tuser, m_tdata[0], m_tdata[48:1], m_tdata[56:49], m_tdata[64:57],
             m_tdata[67:65], m_tdata[73:68], m_tdata[81:74], m_tlast};
      if (ap_q.size() == 0) report_mismatch("unexpected record", 64'(got), 0);
      else begin
        want = ap_q.pop_front();
        if (got.kind != want.kind) report_mismatch("record_kind", got.kind, want.kind);
        if (got.acc != want.acc) report_mismatch("accepted", got.acc, want.acc);
        if (got.bssid != want.bssid) report_mismatch("bssid", got.bssid, want.bssid);
        if (got.chan != want.chan) report_mismatch("channel", got.chan, want.chan);
        if (got.rssi != want.rssi) report_mismatch("rssi", got.rssi, want.rssi);
        if (got.sec != want.sec) report_mismatch("security", got.sec, want.sec);
        if (got.slen != want.slen) report_mismatch("ssid_len", got.slen, want.slen);
        if (got.schar != want.schar) report_mismatch("ssid_char", got.schar, want.schar);
        if (got.last != want.last) report_mismatch("last_of_run", got.last, want.last);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d records outstanding", ap_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls, with a calm window in the middle of the run
  always @(negedge clk) begin
    rx_calm <= (cycles > 6000 && cycles < 9000);
    m_tready <= rx_calm || ($urandom_range(99) >= 34);
  end

  frame_row_t plan[25] = '{
    '{F_OPEN_EMPTY_SSID, 1, 1}, '{F_SSID32_CTRL, 1, 1}, '{F_PROBE_WEP, 1, 1},
    '{F_SHORT, 1, 0}, '{F_ONE_BYTE, 1, 0}, '{F_BAD_FC, 1, 0},
    '{F_GROUP_BSSID, 1, 0}, '{F_ZERO_BSSID, 1, 0}, '{F_SSID33, 1, 0},
    '{F_TRUNCATED, 1, 0}, '{F_NO_SSID, 1, 0}, '{F_BAD_CHAN, 1, 0},
    '{F_DS_CHAN, 0, 0}, '{F_HT_CHAN, 0, 0}, '{F_HT_AFTER_DS, 0, 0},
    '{F_WPA2, 0, 0}, '{F_SAE, 0, 0}, '{F_OWE, 0, 0},
    '{F_RSN_SHORT, 0, 0}, '{F_RSN_BAD_VER, 0, 0}, '{F_RSN_OVERRUN, 0, 0},
    '{F_WPA, 0, 0}, '{F_WPA_AFTER_RSN, 0, 0}, '{F_OVERSIZE, 1, 0},
    '{F_SECOND_SSID, 0, 0}
  };

  initial begin
    logic [7:0] ch;
    logic [7:0] rs;
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    p_pos = '0; p_bad = 0; p_bssid = '0; p_sec = SEC_OPEN; p_chan = '0; p_rssi = '0;
    p_slen = '0; p_seen = '0; p_id = '0; p_len = '0; p_off = '0; p_phase = '0;
    p_cnt = '0; p_stg = STG_START; p_auth = SEC_WPA2;
    foreach (p_ssid[i]) p_ssid[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      build_case(plan[i].fcase, ch, rs);
      send_frame(ch, rs);
      if (plan[i].known && last_acc != plan[i].acc)
        report_mismatch(plan[i].fcase.name(), last_acc, plan[i].acc);
    end

    // hold off until the block has drained every record
    s_tvalid <= 1'b0;
    do @(negedge clk); while (ap_q.size() != 0);

    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      tx_calm = (f >= 20 && f < 30);
      build_random(ch, rs);
      send_frame(ch, rs);
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    waited = 0;
    while (ap_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);

    $display("%0d frames sent, %0d accepted, %0d records checked",
             frames_sent, frames_accepted, records_seen);
    $display("covered rejects, all security classes, channel overrides, oversize frame");
    if (errors == 0 && ap_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d records missing", errors, ap_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
